### rtl/dsp_pkg.sv
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared types, codes and helpers of the deduplicating string pool.
// ----------------------------------------------------------------------------
`default_nettype none

package dsp_pkg;

    // Default sizes
    localparam int ARENA_BYTES_DEF = 65536;
    localparam int MAX_STRING_DEF  = 1024;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Input opcodes
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_MODE  = 2'd1;
    localparam logic [1:0] OP_EMPTY = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic       dynamic_mode;
        logic       clear_counters;
    } in_item_t;

    typedef struct packed {
        logic [16:0] string_offset;
        logic        was_duplicate;
        logic        did_wrap;
        logic        too_long;
        logic [31:0] dup_total;
        logic [31:0] wrap_total;
        logic [31:0] bytes_total;
        logic [16:0] max_offset_seen;
    } out_item_t;

    // Commands from front to back
    typedef enum logic [1:0] {
        CMD_CHAR  = 2'd0,
        CMD_END   = 2'd1,
        CMD_MODE  = 2'd2,
        CMD_EMPTY = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] ch;
        logic       pre_bs;   // push a backslash first
        logic       flag;     // mode for CMD_MODE, clear for CMD_EMPTY
    } cmd_t;

    // Saturating add of two counters
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? COUNT_MAX : sum[31:0];
    endfunction

endpackage

`default_nettype wire

### rtl/deduplicating_string_pool_top.sv
// ----------------------------------------------------------------------------
// deduplicating_string_pool_top
// String pool with escape decoding, duplicate search and a two-half arena.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid/in_stall/in_data) carry string bytes, mode
//   changes and empty-pool requests. A NUL byte ends a string and causes
//   exactly one output word (out_valid/out_stall/out_data), others none.
//   cfg_we/cfg_wdata writes allow_duplicates; the user must do so only while idle, unchecked by the block.
// Timing:
//   The front takes one word per cycle, while the queue is not full,
//   into a four-entry command queue. A kept backslash is pushed before
//   its character. With the search off, the string and its terminator
//   are copied from staging into the arena before out_valid rises; the
//   duplicate search first reads each stored byte from the dedup floor
//   up, terminators included. A match answers after its scan without an
//   append, an over-long string straight from S_END. The back takes the
//   next command in the cycle after the result is accepted; the byte-serial
//   scan sets the rate. in_stall rises only while the queue is full.
// Reset:
//   rst_n clears the pool pointers, counters, queue and escape state.
//   Arena and staging contents are undefined until written.
// Stall:
//   While out_stall is high the result is held and the back waits;
//   the queue keeps filling until full.
// ----------------------------------------------------------------------------
`default_nettype none

module deduplicating_string_pool_top
    import dsp_pkg::*;
#(
    parameter int ARENA_BYTES = ARENA_BYTES_DEF,
    parameter int MAX_STRING  = MAX_STRING_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_we,
    input  wire logic     cfg_wdata,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_item_t     out_data
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t q_cmd;
    cmd_t q_head;

    dsp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    dsp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    dsp_back #(
        .ARENA_BYTES (ARENA_BYTES),
        .MAX_STRING  (MAX_STRING)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### rtl/dsp_front.sv
// ----------------------------------------------------------------------------
// dsp_front
// Accepts input words, resolves backslash escapes and issues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_front
    import dsp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    input  wire logic     q_full,
    output logic          q_push,
    output cmd_t          q_cmd
);

    logic pend_reg;
    logic pend_next;
    logic accept;
    logic emit;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept && emit;

    // Classify the word
    always_comb
    begin
        emit        = 1'b0;
        pend_next   = pend_reg;
        q_cmd       = '{kind: CMD_CHAR, ch: in_data.data_byte, pre_bs: 1'b0, flag: 1'b0};
        unique case (in_data.opcode)
            OP_MODE:
            begin
                emit        = 1'b1;
                q_cmd.kind  = CMD_MODE;
                q_cmd.flag  = in_data.dynamic_mode;
            end
            OP_EMPTY:
            begin
                emit        = 1'b1;
                q_cmd.kind  = CMD_EMPTY;
                q_cmd.flag  = in_data.clear_counters;
            end
            OP_BYTE:
            begin
                emit = 1'b1;
                if (pend_reg)
                begin
                    pend_next = 1'b0;
                    if (in_data.data_byte == CH_N)
                        q_cmd.ch = CH_LF;
                    else if (in_data.data_byte == CH_R)
                        q_cmd.ch = CH_CR;
                    else if (in_data.data_byte == CH_T)
                        q_cmd.ch = CH_TAB;
                    else if (in_data.data_byte == CH_NUL)
                    begin
                        q_cmd.kind   = CMD_END;
                        q_cmd.pre_bs = 1'b1;
                    end
                    else if (in_data.data_byte == CH_BSLASH)
                        pend_next = 1'b1;   // kept backslash, new escape opens
                    else
                        q_cmd.pre_bs = 1'b1;
                end
                else if (in_data.data_byte == CH_NUL)
                    q_cmd.kind = CMD_END;
                else if (in_data.data_byte == CH_BSLASH)
                begin
                    emit      = 1'b0;
                    pend_next = 1'b1;
                end
            end
            default:
                emit = 1'b0;   // drop unused opcode
        endcase
    end

    // Hold escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else if (accept)
            pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

### rtl/dsp_queue.sv
// ----------------------------------------------------------------------------
// dsp_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_queue
    import dsp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      full,
    output logic      empty,
    output cmd_t      head
);

    localparam int PTRW = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            slot_reg [QUEUE_DEPTH];
    logic [PTRW-1:0] wr_reg;
    logic [PTRW-1:0] rd_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (cnt_reg == CNTW'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_cmd;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= (wr_reg == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= (rd_reg == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

### rtl/dsp_back.sv
// ----------------------------------------------------------------------------
// dsp_back
// Executes commands: staging, duplicate scan, append, pool emptying and result output.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_back
    import dsp_pkg::*;
#(
    parameter int ARENA_BYTES = ARENA_BYTES_DEF,
    parameter int MAX_STRING  = MAX_STRING_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    input  wire logic q_empty,
    input  wire cmd_t q_head,
    output logic      q_pop,
    output logic      out_valid,
    input  wire logic out_stall,
    output out_item_t out_data
);

    localparam int TOTAL = 2 * ARENA_BYTES;
    localparam int AW    = $clog2(TOTAL);
    localparam int PW    = $clog2(TOTAL + 1) + 1;
    localparam int SW    = $clog2(MAX_STRING);
    localparam int LW    = $clog2(MAX_STRING + 2);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_CHAR    = 9'b000000010,
        S_END     = 9'b000000100,
        S_ISSUE   = 9'b000001000,
        S_CMP     = 9'b000010000,
        S_APPEND  = 9'b000100000,
        S_COPY_RD = 9'b001000000,
        S_COPY_WR = 9'b010000000,
        S_EMIT    = 9'b100000000
    } state_t;

    // Memories
    logic [7:0] arena_mem   [TOTAL];
    logic [7:0] staging_mem [MAX_STRING];
    logic [7:0] arena_q;
    logic [7:0] stg_q;

    logic          ar_we;
    logic [AW-1:0] ar_wa;
    logic [7:0]    ar_wd;
    logic [AW-1:0] ar_ra;
    logic          stg_we;
    logic [SW-1:0] stg_wa;
    logic [7:0]    stg_wd;
    logic [SW-1:0] stg_ra;

    // State
    state_t        state_reg,  state_next;
    cmd_t          cmd_reg,    cmd_next;
    logic [LW-1:0] len_reg,    len_next;
    logic [PW-1:0] pos_reg,    pos_next;
    logic [PW-1:0] n_reg,      n_next;
    logic          same_reg,   same_next;
    logic [PW-1:0] place_reg,  place_next;
    logic [LW-1:0] idx_reg,    idx_next;
    logic          wrap_reg,   wrap_next;
    logic          dyn_reg,    dyn_next;
    logic [PW-1:0] cursor_reg, cursor_next;
    logic [PW-1:0] floor_reg,  floor_next;
    logic [PW-1:0] fill_reg,   fill_next;
    logic          allow_reg,  allow_next;
    logic [31:0]   dupc_reg,   dupc_next;
    logic [31:0]   wrapc_reg,  wrapc_next;
    logic [31:0]   bytec_reg,  bytec_next;
    logic [PW-1:0] maxo_reg,   maxo_next;
    logic          ov_reg,     ov_next;
    out_item_t     od_reg,     od_next;

    // Per-cycle actions
    logic          push_en;
    logic [7:0]    push_ch;
    logic          empty_en;
    logic          empty_dyn;
    logic          empty_clr;
    logic          eval_en;
    logic          emit_en;
    logic [PW-1:0] emit_off;
    logic          emit_dup;
    logic          emit_wrap;
    logic          emit_tl;
    logic [PW-1:0] addr;
    logic [PW-1:0] wr_pos;
    logic [31:0]   off32;
    logic [31:0]   max32;

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    assign addr   = pos_reg + n_reg;
    assign wr_pos = place_reg + PW'(idx_reg);

    // Main sequencer
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        n_next      = n_reg;
        same_next   = same_reg;
        place_next  = place_reg;
        idx_next    = idx_reg;
        wrap_next   = wrap_reg;
        dyn_next    = dyn_reg;
        cursor_next = cursor_reg;
        floor_next  = floor_reg;
        fill_next   = fill_reg;
        allow_next  = cfg_we ? cfg_wdata : allow_reg;
        dupc_next   = dupc_reg;
        wrapc_next  = wrapc_reg;
        bytec_next  = bytec_reg;
        maxo_next   = maxo_reg;
        ov_next     = ov_reg;
        od_next     = od_reg;
        q_pop       = 1'b0;
        push_en     = 1'b0;
        push_ch     = cmd_reg.ch;
        empty_en    = 1'b0;
        empty_dyn   = dyn_reg;
        empty_clr   = 1'b0;
        eval_en     = 1'b0;
        emit_en     = 1'b0;
        emit_off    = '0;
        emit_dup    = 1'b0;
        emit_wrap   = 1'b0;
        emit_tl     = 1'b0;
        ar_we       = 1'b0;
        ar_wa       = wr_pos[AW-1:0];
        ar_wd       = 8'h00;
        ar_ra       = addr[AW-1:0];
        stg_ra      = n_reg[SW-1:0];
        off32       = '0;
        max32       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                    unique case (q_head.kind)
                        CMD_MODE:
                        begin
                            if (q_head.flag != dyn_reg)
                            begin
                                dyn_next  = q_head.flag;
                                empty_en  = 1'b1;
                                empty_dyn = q_head.flag;
                            end
                        end
                        CMD_EMPTY:
                        begin
                            empty_en  = 1'b1;
                            empty_clr = q_head.flag;
                        end
                        CMD_CHAR:
                        begin
                            push_en = 1'b1;
                            if (q_head.pre_bs)
                            begin
                                push_ch    = CH_BSLASH;
                                state_next = S_CHAR;
                            end
                            else
                                push_ch = q_head.ch;
                        end
                        CMD_END:
                        begin
                            push_en    = q_head.pre_bs;
                            push_ch    = CH_BSLASH;
                            state_next = S_END;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_CHAR:
            begin
                push_en    = 1'b1;
                state_next = S_IDLE;
            end
            S_END:
            begin
                if (32'(len_reg) > 32'(MAX_STRING) || 32'(len_reg) + 32'd2 > 32'(ARENA_BYTES))
                begin
                    emit_en = 1'b1;
                    emit_tl = 1'b1;
                end
                else if (!allow_reg)
                begin
                    pos_next   = floor_reg + 1'b1;
                    n_next     = '0;
                    same_next  = 1'b1;
                    state_next = S_ISSUE;
                end
                else
                    state_next = S_APPEND;
            end
            S_ISSUE:
            begin
                if (addr < fill_reg && 32'(addr) < 32'(TOTAL))
                    state_next = S_CMP;
                else if (n_reg == '0)
                    state_next = S_APPEND;
                else
                    eval_en = 1'b1;
            end
            S_CMP:
            begin
                if (arena_q == CH_NUL)
                    eval_en = 1'b1;
                else
                begin
                    if (32'(n_reg) >= 32'(len_reg) || arena_q != stg_q)
                        same_next = 1'b0;
                    n_next     = n_reg + 1'b1;
                    state_next = S_ISSUE;
                end
            end
            S_APPEND:
            begin
                idx_next   = '0;
                state_next = S_COPY_RD;
                if (fill_reg < floor_reg ||
                    32'(fill_reg - floor_reg) + 32'(len_reg) + 32'd2 > 32'(ARENA_BYTES))
                begin
                    place_next = cursor_reg + 1'b1;
                    fill_next  = cursor_reg + 1'b1;
                    floor_next = cursor_reg;
                    wrapc_next = sat_add(wrapc_reg, 32'd1);
                    wrap_next  = 1'b1;
                end
                else
                begin
                    place_next = fill_reg;
                    wrap_next  = 1'b0;
                end
            end
            S_COPY_RD:
            begin
                stg_ra = idx_reg[SW-1:0];
                if (32'(idx_reg) == 32'(len_reg) + 32'd1)
                begin
                    bytec_next = sat_add(bytec_reg, 32'(len_reg) + 32'd1);
                    fill_next  = wr_pos;
                    emit_en    = 1'b1;
                    emit_off   = place_reg;
                    emit_wrap  = wrap_reg;
                end
                else
                    state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                ar_we      = (32'(wr_pos) < 32'(TOTAL));
                ar_wd      = (idx_reg < len_reg) ? stg_q : CH_NUL;
                idx_next   = idx_reg + 1'b1;
                state_next = S_COPY_RD;
            end
            S_EMIT:
            begin
                if (!out_stall)
                begin
                    ov_next    = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        // End of one stored string: match or move on
        if (eval_en)
        begin
            if (same_reg && 32'(n_reg) == 32'(len_reg))
            begin
                emit_en  = 1'b1;
                emit_dup = 1'b1;
                emit_off = pos_reg;
                dupc_next = sat_add(dupc_reg, 32'd1);
            end
            else
            begin
                pos_next   = addr + 1'b1;
                n_next     = '0;
                same_next  = 1'b1;
                state_next = S_ISSUE;
            end
        end

        // Empty the pool
        if (empty_en)
        begin
            if (empty_dyn)
                cursor_next = '0;
            else
            begin
                cursor_next = PW'(ARENA_BYTES);
                floor_next  = PW'(ARENA_BYTES);
                fill_next   = PW'(ARENA_BYTES + 1);
            end
            if (empty_clr)
            begin
                dupc_next  = '0;
                wrapc_next = '0;
                bytec_next = '0;
                maxo_next  = '0;
            end
        end

        // Append one character to staging
        stg_we = 1'b0;
        stg_wa = len_reg[SW-1:0];
        stg_wd = push_ch;
        if (push_en)
        begin
            if (32'(len_reg) < 32'(MAX_STRING))
            begin
                stg_we   = 1'b1;
                len_next = len_reg + 1'b1;
            end
            else
                len_next = LW'(MAX_STRING + 1);
        end

        // Load the result
        if (emit_en)
        begin
            if (!emit_tl && emit_off > maxo_reg)
                maxo_next = emit_off;
            off32                   = 32'(emit_off);
            max32                   = 32'(maxo_next);
            od_next.string_offset   = off32[16:0];
            od_next.was_duplicate   = emit_dup;
            od_next.did_wrap        = emit_wrap;
            od_next.too_long        = emit_tl;
            od_next.dup_total       = dupc_next;
            od_next.wrap_total      = wrapc_next;
            od_next.bytes_total     = bytec_next;
            od_next.max_offset_seen = max32[16:0];
            len_next                = '0;
            ov_next                 = 1'b1;
            state_next              = S_EMIT;
        end
    end

    // Arena and staging storage
    always_ff @(posedge clk)
    begin
        if (ar_we)
            arena_mem[ar_wa] <= ar_wd;
        arena_q <= arena_mem[ar_ra];
        if (stg_we)
            staging_mem[stg_wa] <= stg_wd;
        stg_q <= staging_mem[stg_ra];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        pos_reg   <= pos_next;
        n_reg     <= n_next;
        same_reg  <= same_next;
        place_reg <= place_next;
        idx_reg   <= idx_next;
        wrap_reg  <= wrap_next;
        od_reg    <= od_next;
    end

    // Control and pool state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            dyn_reg    <= 1'b0;
            cursor_reg <= '0;
            floor_reg  <= '0;
            fill_reg   <= PW'(1);
            allow_reg  <= 1'b0;
            dupc_reg   <= '0;
            wrapc_reg  <= '0;
            bytec_reg  <= '0;
            maxo_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            dyn_reg    <= dyn_next;
            cursor_reg <= cursor_next;
            floor_reg  <= floor_next;
            fill_reg   <= fill_next;
            allow_reg  <= allow_next;
            dupc_reg   <= dupc_next;
            wrapc_reg  <= wrapc_next;
            bytec_reg  <= bytec_next;
            maxo_reg   <= maxo_next;
            ov_reg     <= ov_next;
        end
    end

endmodule

`default_nettype wire

### rtl/dsp_checker.sv
// ----------------------------------------------------------------------------
// dsp_port_checks
// Port-level checks of the string pool, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_port_checks
    import dsp_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Reject an over-long string with a clean result
    a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.too_long |->
            out_data.string_offset == 17'd0 && !out_data.was_duplicate &&
            !out_data.did_wrap)
        else $error("too-long result carries placement flags");

    // Match and wrap exclude each other
    a_dup_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.was_duplicate && out_data.did_wrap))
        else $error("result both duplicate and wrapped");

endmodule

bind deduplicating_string_pool_top dsp_port_checks u_dsp_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
